// ===== hw/rtl/isd_pkg.sv =====
// Shared constants and register codes for the inductor steering deviation block.
package isd_pkg;

  // Input sample width default
  localparam int SAMPLE_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int LIMIT_W    = 14;
  localparam int LEVEL_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_CURVE_SUM_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SUM_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEAK_LEVEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_DIFF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_DIFF      = 3'd4;

  localparam logic [LIMIT_W-1:0] CURVE_SUM_LIMIT_RST = 14'd518;
  localparam logic [LIMIT_W-1:0] INNER_SUM_LIMIT_RST = 14'd277;
  localparam logic [LEVEL_W-1:0] WEAK_LEVEL_RST      = 12'd240;
  localparam logic [LEVEL_W-1:0] LARGE_DIFF_RST      = 12'd400;
  localparam logic [LEVEL_W-1:0] SMALL_DIFF_RST      = 12'd100;

  // Deviation result
  localparam int DEV_W = 14;

  // Ratio gains; the quotient never exceeds the gain, so it fits QUOT_W bits
  localparam int GAIN_W = 13;
  localparam int QUOT_W = 13;
  localparam logic [GAIN_W-1:0] GAIN_LARGE_LEFT  = 13'd5000;
  localparam logic [GAIN_W-1:0] GAIN_LARGE_RIGHT = 13'd5200;
  localparam logic [GAIN_W-1:0] GAIN_SMALL_LEFT  = 13'd3500;
  localparam logic [GAIN_W-1:0] GAIN_SMALL_RIGHT = 13'd3600;

  // Outer-sensor fixed steering values
  localparam logic signed [DEV_W-1:0] DEV_OUTER_LEFT  = -14'sd1500;
  localparam logic signed [DEV_W-1:0] DEV_OUTER_RIGHT = 14'sd1600;

  // Signal-loss levels (fit in the narrowest sample width)
  localparam logic [7:0] LOSS_OUTER = 8'd10;
  localparam logic [7:0] LOSS_INNER = 8'd20;

endpackage

// ===== hw/rtl/isd_if.sv =====
// Valid/ready channel interfaces: sample input, deviation result, config write.
interface isd_in_if #(
  parameter int SAMPLE_BITS = isd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] right_outer;
  logic [SAMPLE_BITS-1:0] right_inner;
  logic [SAMPLE_BITS-1:0] left_inner;
  logic [SAMPLE_BITS-1:0] left_outer;

  modport source (output valid, right_outer, right_inner, left_inner, left_outer,
                  input ready);
  modport sink   (input valid, right_outer, right_inner, left_inner, left_outer,
                  output ready);
endinterface

interface isd_out_if;
  import isd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DEV_W-1:0] deviation;
  logic                    bend_flag;

  modport source (output valid, deviation, bend_flag, input ready);
  modport sink   (input valid, deviation, bend_flag, output ready);
endinterface

interface isd_cfg_if;
  import isd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/isd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ratio path.
module isd_div #(
  parameter int DEN_W = isd_pkg::SAMPLE_BITS_DEF + 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [isd_pkg::QUOT_W+DEN_W-1:0]      num,
  input  logic [DEN_W-1:0]                      den,
  output logic                                  busy,
  output logic                                  done,
  output logic [isd_pkg::QUOT_W-1:0]            quot
);
  import isd_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic [DEN_W-1:0]  rem_r;
  logic [QUOT_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W:0]    diff_w;

  // One trial subtraction; dividend N < 2^QUOT_W * den keeps the remainder below den
  assign trial  = {rem_r, q_r[QUOT_W-1]};
  assign fits   = trial >= {1'b0, den};
  assign diff_w = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_r <= !start && busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: high part of the dividend seeds the remainder, low part shifts through q_r
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[QUOT_W+DEN_W-1:QUOT_W];
      q_r   <= num[QUOT_W-1:0];
    end else if (busy_r) begin
      rem_r <= fits ? diff_w[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[QUOT_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

`ifndef SYNTH
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> den != '0) else $error("divider started with zero divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
`endif

endmodule

// ===== hw/rtl/inductor_steering_deviation_top.sv =====
// Steering deviation from four inductor samples: thresholds, ratio and hold.
// Ratio items pass grade, multiply, 13 divider steps and finish before out
// valid rises; other items go from grade straight to finish.
// One item at a time: a new input is taken only in idle; the divider makes
// one quotient bit per cycle, and a waiting result stalls the finish.
// Reset (synchronous, rst_n low): registers to 518/277/240/400/100,
// previous deviation to 0, sequencer idle, no result pending.
module inductor_steering_deviation_top #(
  parameter int SAMPLE_BITS = isd_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  isd_in_if.sink    in_ch,
  isd_out_if.source out_ch,
  isd_cfg_if.sink   cfg_ch
);
  import isd_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = SB + 2;
  localparam int DEN_W  = SB + 1;
  localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam int LVL_W  = (SB > LEVEL_W) ? SB : LEVEL_W;
  localparam int PROD_W = GAIN_W + SB;
  localparam int NUM_W  = QUOT_W + DEN_W;

  typedef enum logic [2:0] {ST_IDLE, ST_CALC, ST_MUL, ST_DIV, ST_FIN} state_t;

  state_t state_r;

  // Configuration registers
  logic [LIMIT_W-1:0] curve_lim_r, inner_lim_r;
  logic [LEVEL_W-1:0] weak_r, large_r, small_r;

  // Captured samples
  logic [SB-1:0] ro_r, ri_r, li_r, lo_r;

  // Graded item
  logic                    ratio_r;
  logic                    left_r;
  logic                    curve_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [SB-1:0]           diff_r;
  logic [DEN_W-1:0]        den_r;
  logic signed [DEV_W-1:0] dev_fix_r;
  logic signed [DEV_W-1:0] prev_r;

  // Result register
  logic                    out_valid_r;
  logic signed [DEV_W-1:0] out_dev_r;
  logic                    out_curve_r;

  // Grading logic
  logic [SUM_W-1:0]        sum_w;
  logic                    curve_w;
  logic                    inner_w;
  logic                    loss_w;
  logic                    left_w;
  logic [SB-1:0]           diff_w;
  logic                    large_w;
  logic                    small_w;
  logic                    ratio_w;
  logic [GAIN_W-1:0]       gain_w;
  logic signed [DEV_W-1:0] dev_fix_w;

  // Divider hookup and finish
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [QUOT_W-1:0]       div_quot;
  logic [PROD_W-1:0]       prod_w;
  logic signed [DEV_W-1:0] quot_s;
  logic signed [DEV_W-1:0] dev_w;
  logic                    load_out;

  // Config writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_lim_r <= CURVE_SUM_LIMIT_RST;
      inner_lim_r <= INNER_SUM_LIMIT_RST;
      weak_r      <= WEAK_LEVEL_RST;
      large_r     <= LARGE_DIFF_RST;
      small_r     <= SMALL_DIFF_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CURVE_SUM_LIMIT: curve_lim_r <= cfg_ch.data[LIMIT_W-1:0];
        REG_INNER_SUM_LIMIT: inner_lim_r <= cfg_ch.data[LIMIT_W-1:0];
        REG_WEAK_LEVEL:      weak_r      <= cfg_ch.data[LEVEL_W-1:0];
        REG_LARGE_DIFF:      large_r     <= cfg_ch.data[LEVEL_W-1:0];
        REG_SMALL_DIFF:      small_r     <= cfg_ch.data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Grade the captured samples: curve, mode, gain and direct results
  always_comb begin
    sum_w   = SUM_W'(ro_r) + SUM_W'(ri_r) + SUM_W'(li_r) + SUM_W'(lo_r);
    curve_w = CMP_W'(sum_w) > CMP_W'(curve_lim_r);
    inner_w = (CMP_W'(sum_w) <= CMP_W'(inner_lim_r)) &&
              ((LVL_W'(ri_r) < LVL_W'(weak_r)) || (LVL_W'(li_r) < LVL_W'(weak_r)));
    loss_w  = (ro_r < SB'(LOSS_OUTER)) && (ri_r < SB'(LOSS_INNER)) &&
              (li_r < SB'(LOSS_INNER)) && (lo_r < SB'(LOSS_OUTER));
    left_w  = li_r > ri_r;
    diff_w  = left_w ? (li_r - ri_r) : (ri_r - li_r);
    large_w = LVL_W'(diff_w) > LVL_W'(large_r);
    small_w = LVL_W'(diff_w) > LVL_W'(small_r);
    ratio_w = !loss_w && inner_w && (large_w || small_w);
    if (large_w) begin
      gain_w = left_w ? GAIN_LARGE_LEFT : GAIN_LARGE_RIGHT;
    end else begin
      gain_w = left_w ? GAIN_SMALL_LEFT : GAIN_SMALL_RIGHT;
    end
    if (loss_w) begin
      dev_fix_w = prev_r;
    end else if (inner_w) begin
      dev_fix_w = '0;
    end else begin
      dev_fix_w = (lo_r > ro_r) ? DEV_OUTER_LEFT : DEV_OUTER_RIGHT;
    end
  end

  // Multiply stage feeds the divider
  assign prod_w    = PROD_W'(gain_r) * PROD_W'(diff_r);
  assign div_start = (state_r == ST_MUL);

  isd_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (NUM_W'(prod_w)),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Finish: sign the quotient or take the direct value
  assign quot_s   = signed'({1'b0, div_quot});
  assign dev_w    = ratio_r ? (left_r ? -quot_s : quot_s) : dev_fix_r;
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = (state_r == ST_IDLE);

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      // A new result may replace one that leaves in the same cycle
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_r <= ratio_w ? ST_MUL : ST_FIN;
        end
        ST_MUL: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            prev_r  <= dev_w;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ro_r <= in_ch.right_outer;
      ri_r <= in_ch.right_inner;
      li_r <= in_ch.left_inner;
      lo_r <= in_ch.left_outer;
    end
    if (state_r == ST_CALC) begin
      ratio_r   <= ratio_w;
      left_r    <= left_w;
      curve_r   <= curve_w;
      gain_r    <= gain_w;
      diff_r    <= diff_w;
      den_r     <= DEN_W'(li_r) + DEN_W'(ri_r);
      dev_fix_r <= dev_fix_w;
    end
    if (load_out) begin
      out_dev_r   <= dev_w;
      out_curve_r <= curve_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.deviation = out_dev_r;
  assign out_ch.bend_flag = out_curve_r;

`ifndef SYNTH
  a_div_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && !div_done |-> div_busy)
    else $error("sequencer waits on an idle divider");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_DIV)) else $error("divider busy outside divide state");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished result not presented");
  a_ratio_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_quot <= GAIN_LARGE_RIGHT) else $error("ratio exceeds largest gain");
`endif

endmodule
